[hw/rtl/bptc_pkg.sv]
package bptc_pkg;

	// Field widths
	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int IDX_W   = 3;
	localparam int DT_W    = 25;
	localparam int MUL_W   = 42;
	localparam int DT2_W   = 50;
	localparam int T2_W    = 17;
	localparam int D_W     = 19;
	localparam int SQ_W    = 38;
	localparam int CORR_W  = 40;
	localparam int ACC_W   = 42;
	localparam int LO_W    = 21;
	localparam int HI_W    = ACC_W - LO_W;
	localparam int PLO_W   = RAW_W + LO_W;
	localparam int PHI_W   = RAW_W + 1 + HI_W;
	localparam int DIFF_W  = PHI_W + 1;
	localparam int PRESS_W = 32;
	localparam int TEMP_W  = 19;

	// Input to result, in clock cycles
	localparam int LATENCY = 9;

	// Temperature thresholds in 0.01 degC
	localparam logic signed [TEMP_W-1:0] T_REF       = 19'sd2000;
	localparam logic signed [D_W-1:0]    T_COLD_DIST = 19'sd3500;

	// Calibration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_PRESS_SENS = 3'd0,
		REG_PRESS_OFF  = 3'd1,
		REG_SENS_TCO   = 3'd2,
		REG_OFF_TCO    = 3'd3,
		REG_REF_TEMP   = 3'd4,
		REG_TEMP_COEF  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] press_sens;
		logic [CAL_W-1:0] press_off;
		logic [CAL_W-1:0] sens_tco;
		logic [CAL_W-1:0] off_tco;
		logic [CAL_W-1:0] ref_temp;
		logic [CAL_W-1:0] temp_coef;
	} cal_t;

	// Handoff from the temperature front end to the pressure back end
	typedef struct packed {
		logic                       valid;
		logic [RAW_W-1:0]           up;
		logic signed [ACC_W-1:0]    off1;
		logic signed [ACC_W-1:0]    sens1;
		logic signed [SQ_W-1:0]     sq_warm;
		logic signed [SQ_W-1:0]     sq_cold;
		logic                       below_ref;
		logic                       below_cold;
		logic signed [TEMP_W-1:0]   temp;
	} front_t;

endpackage

[hw/rtl/bptc_cfg_regs.sv]
module bptc_cfg_regs import bptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CAL_W-1:0] wr_data,
	output cal_t             cal
);

	cal_t cal_q;

	// Write the addressed calibration word, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PRESS_SENS: cal_q.press_sens <= wr_data;
				REG_PRESS_OFF:  cal_q.press_off  <= wr_data;
				REG_SENS_TCO:   cal_q.sens_tco   <= wr_data;
				REG_OFF_TCO:    cal_q.off_tco    <= wr_data;
				REG_REF_TEMP:   cal_q.ref_temp   <= wr_data;
				REG_TEMP_COEF:  cal_q.temp_coef  <= wr_data;
				default:        cal_q            <= cal_q;
			endcase
		end
	end

	assign cal = cal_q;

endmodule

[hw/rtl/bptc_front.sv]
module bptc_front import bptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cal_t             cal,
	input  logic             in_valid,
	input  logic [RAW_W-1:0] raw_temperature,
	input  logic [RAW_W-1:0] raw_pressure,
	output front_t           front
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic [RAW_W-1:0]         up_s1, up_s2, up_s3, up_s4;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [MUL_W-1:0]  moff_s2, msens_s2, mtemp_s2;
	logic signed [DT2_W-1:0]  mdt2_s2;
	logic signed [ACC_W-1:0]  off1_s3, sens1_s3, off1_s4, sens1_s4;
	logic signed [D_W-1:0]    dwarm_s3, dcold_s3;
	logic [T2_W-1:0]          t2_s3;
	logic signed [SQ_W-1:0]   sqwarm_s4, sqcold_s4;
	logic                     lt_s4, cold_s4;
	logic signed [TEMP_W-1:0] temp_s4;

	logic signed [MUL_W-1:0]  dwarm_full;
	logic signed [D_W-1:0]    dwarm;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Temperature offset from the reference point
	assign dwarm_full = mtemp_s2 >>> 23;
	assign dwarm      = dwarm_full[D_W-1:0];

	always_ff @(posedge clk) begin
		// Stage 1: difference to the reference temperature
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'b0});
		up_s1 <= raw_pressure;

		// Stage 2: all products with dt, the first-order ones and dt squared
		moff_s2  <= $signed({1'b0, cal.off_tco}) * dt_s1;
		msens_s2 <= $signed({1'b0, cal.sens_tco}) * dt_s1;
		mtemp_s2 <= $signed({1'b0, cal.temp_coef}) * dt_s1;
		mdt2_s2  <= dt_s1 * dt_s1;
		up_s2    <= up_s1;

		// Stage 3: first-order offset, sensitivity and temperature deltas
		off1_s3  <= $signed({10'b0, cal.press_off, 16'b0}) + (moff_s2 >>> 7);
		sens1_s3 <= $signed({11'b0, cal.press_sens, 15'b0}) + (msens_s2 >>> 8);
		dwarm_s3 <= dwarm;
		dcold_s3 <= dwarm + T_COLD_DIST;
		t2_s3    <= mdt2_s2[31+T2_W-1:31];
		up_s3    <= up_s2;

		// Stage 4: second-order squares and final temperature
		sqwarm_s4 <= dwarm_s3 * dwarm_s3;
		sqcold_s4 <= dcold_s3 * dcold_s3;
		lt_s4     <= dwarm_s3[D_W-1];
		cold_s4   <= dcold_s3[D_W-1];
		temp_s4   <= dwarm_s3[D_W-1] ?
			T_REF + dwarm_s3 - $signed({2'b0, t2_s3}) : T_REF + dwarm_s3;
		off1_s4   <= off1_s3;
		sens1_s4  <= sens1_s3;
		up_s4     <= up_s3;
	end

	assign front.valid      = valid_s4;
	assign front.up         = up_s4;
	assign front.off1       = off1_s4;
	assign front.sens1      = sens1_s4;
	assign front.sq_warm    = sqwarm_s4;
	assign front.sq_cold    = sqcold_s4;
	assign front.below_ref  = lt_s4;
	assign front.below_cold = cold_s4;
	assign front.temp       = temp_s4;

endmodule

[hw/rtl/bptc_back.sv]
module bptc_back import bptc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  front_t                    front,
	output logic                      out_valid,
	output logic signed [PRESS_W-1:0] press,
	output logic signed [TEMP_W-1:0]  temp
);

	logic valid_s5, valid_s6, valid_s7, valid_s8, valid_s9;

	logic [RAW_W-1:0]          up_s5, up_s6;
	logic signed [ACC_W-1:0]   off1_s5, sens1_s5, off_s6, sens_s6, off_s7, off_s8;
	logic signed [CORR_W-1:0]  coff_s5, csens_s5;
	logic [PLO_W-1:0]          plo_s7;
	logic signed [PHI_W-1:0]   phi_s7, sum_s8;
	logic signed [PRESS_W-1:0] press_s9;
	logic signed [TEMP_W-1:0]  temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;

	logic signed [CORR_W-1:0]  sqw, sqc, warm5, cold7, cold11;
	logic signed [CORR_W-1:0]  coff_n, csens_n;
	logic signed [DIFF_W-1:0]  diff;

	// Constant multiples of the squares by shift and add
	assign sqw    = {{(CORR_W-SQ_W){front.sq_warm[SQ_W-1]}}, front.sq_warm};
	assign sqc    = {{(CORR_W-SQ_W){front.sq_cold[SQ_W-1]}}, front.sq_cold};
	assign warm5  = sqw + (sqw <<< 2);
	assign cold7  = (sqc <<< 3) - sqc;
	assign cold11 = (sqc <<< 3) + (sqc <<< 1) + sqc;

	// Second-order corrections below the reference, cold term only below the cold threshold
	always_comb begin
		coff_n  = '0;
		csens_n = '0;
		if (front.below_ref) begin
			coff_n  = (warm5 >>> 1) + (front.below_cold ? cold7 : '0);
			csens_n = (warm5 >>> 2) + (front.below_cold ? (cold11 >>> 1) : '0);
		end
	end

	// Final difference, then scale down
	assign diff = $signed({sum_s8[PHI_W-1], sum_s8})
		- $signed({{(DIFF_W-ACC_W){off_s8[ACC_W-1]}}, off_s8});

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s5 <= front.valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		// Stage 5: correction terms
		coff_s5  <= coff_n;
		csens_s5 <= csens_n;
		off1_s5  <= front.off1;
		sens1_s5 <= front.sens1;
		up_s5    <= front.up;
		temp_s5  <= front.temp;

		// Stage 6: apply corrections
		off_s6  <= off1_s5 - {{(ACC_W-CORR_W){coff_s5[CORR_W-1]}}, coff_s5};
		sens_s6 <= sens1_s5 - {{(ACC_W-CORR_W){csens_s5[CORR_W-1]}}, csens_s5};
		up_s6   <= up_s5;
		temp_s6 <= temp_s5;

		// Stage 7: pressure product in two halves of the sensitivity
		plo_s7  <= up_s6 * sens_s6[LO_W-1:0];
		phi_s7  <= $signed({1'b0, up_s6}) * $signed(sens_s6[ACC_W-1:LO_W]);
		off_s7  <= off_s6;
		temp_s7 <= temp_s6;

		// Stage 8: recombine, already divided by two to the 21st
		sum_s8  <= phi_s7 + $signed({{(PHI_W-(PLO_W-LO_W)){1'b0}}, plo_s7[PLO_W-1:LO_W]});
		off_s8  <= off_s7;
		temp_s8 <= temp_s7;

		// Stage 9: subtract offset and keep the low 32 bits of the scaled result
		press_s9 <= diff[DIFF_W-1:15];
		temp_s9  <= temp_s8;
	end

	assign out_valid = valid_s9;
	assign press     = press_s9;
	assign temp      = temp_s9;

endmodule

[hw/rtl/baro_pressure_temp_compensation_core.sv]
// Barometer compensation core.
// Six calibration words are written through wr_en / wr_index / wr_data, one
// per cycle, with no wait; indexes past the last register are ignored. Write
// them only while no request is in flight.
// A request is a raw temperature and raw pressure pair, taken at every
// rising edge with start high. busy is always low: a new pair can enter in
// every cycle.
// The compensated pair appears on pressure_out and temperature_out with done
// high for exactly one cycle, once the request has passed the pipeline. Results
// leave in request order; the receiver cannot stall, so nothing is held.
// Throughput is one pair per cycle; each pair passes through the nine-stage
// pipeline (first-order products, squares, corrections, then the pressure
// product split in two 24 x 21 bit halves and recombined).
// Reset clears all calibration words to zero and drops any request in flight.
module baro_pressure_temp_compensation_core import bptc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [RAW_W-1:0]          raw_temperature,
	input  logic [RAW_W-1:0]          raw_pressure,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic [CAL_W-1:0]          wr_data,
	output logic                      done,
	output logic signed [PRESS_W-1:0] pressure_out,
	output logic signed [TEMP_W-1:0]  temperature_out
);

	cal_t   cal;
	front_t front;

	assign busy = 1'b0;

	bptc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cal      (cal)
	);

	bptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (start && !busy),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.front           (front)
	);

	bptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.front     (front),
		.out_valid (done),
		.press     (pressure_out),
		.temp      (temperature_out)
	);

	// Every result comes from a matching earlier request
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching request");

	// Every request produces a result
	a_request_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request lost in pipeline");

	// The cold correction only applies inside the below-reference range
	a_cold_in_warm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(front.valid && front.below_cold) |-> front.below_ref)
		else $error("cold correction outside second-order range");

endmodule

[sim/baro_pressure_temp_compensation_core_test.sv]
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_core_test;
	import bptc_pkg::*;

	localparam int    WATCHDOG_LIMIT = 1000;
	localparam int    PHASE_ITEMS    = 105;
	localparam int    N_PHASES       = 6;
	localparam int    N_DIRECTED     = 22;
	localparam longint TEMP_REF      = 2000;
	localparam longint TEMP_COLD     = -1500;

	// Indexes past the last calibration word; writes there must be dropped
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	// A typical factory calibration
	localparam logic [CAL_W-1:0] TYP_PRESS_SENS = 16'd40127;
	localparam logic [CAL_W-1:0] TYP_PRESS_OFF  = 16'd36924;
	localparam logic [CAL_W-1:0] TYP_SENS_TCO   = 16'd23317;
	localparam logic [CAL_W-1:0] TYP_OFF_TCO    = 16'd23282;
	localparam logic [CAL_W-1:0] TYP_REF_TEMP   = 16'd33464;
	localparam logic [CAL_W-1:0] TYP_TEMP_COEF  = 16'd28312;

	typedef enum logic [0:0] {ROW_WRITE, ROW_REQUEST} row_kind_t;
	typedef enum int {CAL_MAX, CAL_TYPICAL, CAL_RANDOM, CAL_MIXED} cal_mode_t;

	typedef struct packed {
		logic signed [PRESS_W-1:0] pressure;
		logic signed [TEMP_W-1:0]  temperature;
	} reading_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [IDX_W-1:0]          index;
		logic [CAL_W-1:0]          data;
		logic [RAW_W-1:0]          rt;
		logic [RAW_W-1:0]          rp;
		logic                      check;
		logic signed [PRESS_W-1:0] exp_press;
		logic signed [TEMP_W-1:0]  exp_temp;
	} stim_row_t;

	// Rows with check set carry a hand-derived reading; the rest go to the predictor
	stim_row_t directed_rows [N_DIRECTED] = '{
		// all calibration words zero after reset: pressure 0, temperature 20.00 C
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'h000000, 24'h000000, 1'b1, 32'sd0, 19'sd2000},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'sd0, 19'sd2000},
		// offset alone: pressure is -(65535 * 65536) / 32768
		'{ROW_WRITE,   REG_PRESS_OFF,  16'hFFFF, 24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'h000000, 24'h000000, 1'b1,
			-32'sd131070, 19'sd2000},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
			-32'sd131070, 19'sd2000},
		// writes to unused indexes change nothing
		'{ROW_WRITE,   REG_SPARE_A,    16'hFFFF, 24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_WRITE,   REG_SPARE_B,    16'h1234, 24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'h123456, 24'hABCDEF, 1'b1,
			-32'sd131070, 19'sd2000},
		// typical calibration
		'{ROW_WRITE, REG_PRESS_SENS, TYP_PRESS_SENS, 24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_WRITE, REG_PRESS_OFF,  TYP_PRESS_OFF,  24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_WRITE, REG_SENS_TCO,   TYP_SENS_TCO,   24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_WRITE, REG_OFF_TCO,    TYP_OFF_TCO,    24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_WRITE, REG_REF_TEMP,   TYP_REF_TEMP,   24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		'{ROW_WRITE, REG_TEMP_COEF,  TYP_TEMP_COEF,  24'h0, 24'h0, 1'b0, 32'sd0, 19'sd0},
		// warm reading, exactly 20.00 C, and one count below it
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'd8569524, 24'd9085466, 1'b0, 32'sd0, 19'sd0},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'd8566784, 24'd9085466, 1'b0, 32'sd0, 19'sd0},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'd8566783, 24'd9085466, 1'b0, 32'sd0, 19'sd0},
		// exactly -15.00 C before correction, then one step colder
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'd7529764, 24'd8000000, 1'b0, 32'sd0, 19'sd0},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'd7529763, 24'd8000000, 1'b0, 32'sd0, 19'sd0},
		// deep cold and hot raw extremes
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'd7000000, 24'd8000000, 1'b0, 32'sd0, 19'sd0},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'h000000, 24'hFFFFFF, 1'b0, 32'sd0, 19'sd0},
		'{ROW_REQUEST, REG_PRESS_SENS, 16'h0, 24'hFFFFFF, 24'h000000, 1'b0, 32'sd0, 19'sd0}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [RAW_W-1:0]          raw_temperature;
	logic [RAW_W-1:0]          raw_pressure;
	logic                      wr_en;
	logic [IDX_W-1:0]          wr_index;
	logic [CAL_W-1:0]          wr_data;
	logic                      done;
	logic signed [PRESS_W-1:0] pressure_out;
	logic signed [TEMP_W-1:0]  temperature_out;

	// Expectation that travels with the request being driven
	logic                      req_check;
	reading_t                  req_want;

	cal_t     cal_model;
	reading_t pending_readings [$];
	int       mismatches;
	int       requests_taken;
	int       readings_seen;
	int       cool_readings;
	int       cold_readings;
	int       cal_sets;
	int       quiet_cycles;

	baro_pressure_temp_compensation_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.done            (done),
		.pressure_out    (pressure_out),
		.temperature_out (temperature_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Second-order compensation of one raw pair, 64-bit signed throughout
	function automatic reading_t compensate(input logic [RAW_W-1:0] rt,
			input logic [RAW_W-1:0] rp, input cal_t c);
		longint   ut, up, dt, off, sens, tmp, d, press;
		longint   c1, c2, c3, c4, c5, c6;
		reading_t r;
		ut = rt;
		up = rp;
		c1 = c.press_sens;
		c2 = c.press_off;
		c3 = c.sens_tco;
		c4 = c.off_tco;
		c5 = c.ref_temp;
		c6 = c.temp_coef;
		dt   = ut - c5 * 256;
		off  = c2 * 65536 + ((c4 * dt) >>> 7);
		sens = c1 * 32768 + ((c3 * dt) >>> 8);
		tmp  = TEMP_REF + ((dt * c6) >>> 23);
		if (tmp < TEMP_REF) begin
			d = tmp - TEMP_REF;
			d = 5 * d * d;
			off  -= d >>> 1;
			sens -= d >>> 2;
			if (tmp < TEMP_COLD) begin
				d = tmp - TEMP_COLD;
				d = d * d;
				off  -= 7 * d;
				sens -= (11 * d) >>> 1;
			end
			tmp -= (dt * dt) >>> 31;
		end
		press = (((up * sens) >>> 21) - off) >>> 15;
		r.pressure    = press[PRESS_W-1:0];
		r.temperature = tmp[TEMP_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at %0t, reading %0d: %s got %0d, want %0d",
			$time, readings_seen, what, got, want);
		mismatches++;
	endtask

	// Check each result against the oldest expectation, then log new requests
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_readings.size() == 0) begin
					report_mismatch("result with no request pending, pressure",
						pressure_out, 0);
				end else begin
					want = pending_readings.pop_front();
					if (pressure_out !== want.pressure)
						report_mismatch("pressure_out", pressure_out, want.pressure);
					if (temperature_out !== want.temperature)
						report_mismatch("temperature_out", temperature_out, want.temperature);
					readings_seen++;
				end
			end
			if (start && !busy) begin
				want = req_check ? req_want : compensate(raw_temperature, raw_pressure, cal_model);
				if (want.temperature < TEMP_REF) cool_readings++;
				if (want.temperature < TEMP_COLD) cold_readings++;
				pending_readings.push_back(want);
				requests_taken++;
			end
		end
	end

	// Abort when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || wr_en || done || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("baro_pressure_temp_compensation_core_test NOT OK");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the write
	task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			REG_PRESS_SENS: cal_model.press_sens = val;
			REG_PRESS_OFF:  cal_model.press_off  = val;
			REG_SENS_TCO:   cal_model.sens_tco   = val;
			REG_OFF_TCO:    cal_model.off_tco    = val;
			REG_REF_TEMP:   cal_model.ref_temp   = val;
			REG_TEMP_COEF:  cal_model.temp_coef  = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Hold the request until taken; start stays high for a back-to-back follower
	task automatic send_request(input logic [RAW_W-1:0] rt, input logic [RAW_W-1:0] rp,
			input logic check, input reading_t want);
		start           <= 1'b1;
		raw_temperature <= rt;
		raw_pressure    <= rp;
		req_check       <= check;
		req_want        <= want;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Drain the pipeline before touching the calibration words
	task automatic settle();
		start <= 1'b0;
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	function automatic logic [CAL_W-1:0] pick_cal(input cal_mode_t mode,
			input logic [CAL_W-1:0] typical);
		case (mode)
			CAL_MAX:     return '1;
			CAL_TYPICAL: return typical;
			CAL_RANDOM:  return CAL_W'($urandom);
			default: begin
				case ($urandom_range(2))
					0:       return '0;
					1:       return '1;
					default: return CAL_W'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic program_cal(input cal_mode_t mode);
		write_cal(REG_PRESS_SENS, pick_cal(mode, TYP_PRESS_SENS));
		write_cal(REG_PRESS_OFF,  pick_cal(mode, TYP_PRESS_OFF));
		write_cal(REG_SENS_TCO,   pick_cal(mode, TYP_SENS_TCO));
		write_cal(REG_OFF_TCO,    pick_cal(mode, TYP_OFF_TCO));
		write_cal(REG_REF_TEMP,   pick_cal(mode, TYP_REF_TEMP));
		write_cal(REG_TEMP_COEF,  pick_cal(mode, TYP_TEMP_COEF));
		if ($urandom_range(1))
			write_cal($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CAL_W'($urandom));
		wr_en <= 1'b0;
		cal_sets++;
	endtask

	// Half the readings around the reference point so that the cold branches are hit
	function automatic logic [RAW_W-1:0] pick_raw_temp();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: return RAW_W'($urandom);
			4, 5, 6, 7: v = int'(cal_model.ref_temp) * 256 + int'($urandom_range(1 << 22)) - (1 << 21);
			8:          return $urandom_range(1) ? '1 : '0;
			default:    v = int'(cal_model.ref_temp) * 256 + int'($urandom_range(512)) - 256;
		endcase
		if (v < 0) v = 0;
		if (v > 24'hFFFFFF) v = 24'hFFFFFF;
		return v[RAW_W-1:0];
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw_press();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	initial begin
		cal_mode_t  phase_mode [N_PHASES];
		int         phase_idle [N_PHASES];
		row_kind_t  prev_kind;
		stim_row_t  row;
		arst_n          = 1'b0;
		start           = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		raw_temperature = '0;
		raw_pressure    = '0;
		req_check       = 1'b0;
		req_want        = '0;
		cal_model       = '0;
		mismatches      = 0;
		requests_taken  = 0;
		readings_seen   = 0;
		cool_readings   = 0;
		cold_readings   = 0;
		cal_sets        = 2;
		quiet_cycles    = 0;
		phase_mode = '{CAL_MAX, CAL_TYPICAL, CAL_RANDOM, CAL_MIXED, CAL_RANDOM, CAL_MIXED};
		phase_idle = '{0, 48, 21, 48, 0, 21};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		prev_kind = ROW_WRITE;
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				if (prev_kind == ROW_REQUEST) settle();
				write_cal(row.index, row.data);
			end else begin
				wr_en <= 1'b0;
				send_request(row.rt, row.rp, row.check, '{row.exp_press, row.exp_temp});
			end
			prev_kind = row.kind;
		end
		cal_sets++;

		// Random phases, each with its own calibration and idle pattern
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			program_cal(phase_mode[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_request(pick_raw_temp(), pick_raw_press(), 1'b0, '0);
				// Idle each following cycle with the phase's chance
				while ($urandom_range(99) < phase_idle[ph])
					idle_for(1);
			end
		end

		start <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		$display("Compensated %0d readings (%0d directed) over %0d calibration sets,",
			readings_seen, N_DIRECTED - 9, cal_sets);
		$display("%0d of them below 20 C and %0d below -15 C; %0d mismatches.",
			cool_readings, cold_readings, mismatches);
		if (mismatches == 0 && requests_taken == readings_seen)
			$display("baro_pressure_temp_compensation_core_test OK");
		else
			$display("baro_pressure_temp_compensation_core_test NOT OK");
		$finish;
	end

endmodule
